FILE: hdl/alpha_blend_pixel_format_write_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the alpha blend pixel format write unit
// Shared property wrappers used by the interface checker.
// ----------------------------------------------------------------------------
`ifndef ALPHA_BLEND_PIXEL_FORMAT_WRITE_UNIT_DEFINES_SVH
`define ALPHA_BLEND_PIXEL_FORMAT_WRITE_UNIT_DEFINES_SVH

// Checked at every clock edge outside of reset.
`define ABPFW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ABPFW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/abpfw_pkg.sv
// ----------------------------------------------------------------------------
// Alpha blend pixel format write package
// Payload types and register indexes shared by the unit and its checker.
// ----------------------------------------------------------------------------
package abpfw_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 20;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_SIZES     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_POSITIONS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYTES_PER_PIXEL   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_PITCH        = 2'd3;

   typedef struct packed {
      logic [11:0] x_pos;
      logic [11:0] y_pos;
      logic [31:0] src_pixel;
      logic [31:0] dst_raw;
   } req_payload_type;

   typedef struct packed {
      logic        write_enable;
      logic [27:0] byte_offset;
      logic [31:0] pixel_value;
   } rsp_payload_type;

endpackage

FILE: hdl/alpha_blend_pixel_format_write_unit.sv
// Throughput: one transaction per cycle unless rsp_stall holds a full
// pipeline; the three register stages are separated by the blend multipliers
// and the offset multiply-add.
// Reset clears all valid bits and loads the default RGB888/ARGB8888 layout,
// four bytes per pixel and a line pitch of 4096 bytes.
// ----------------------------------------------------------------------------
// Alpha blend pixel format write unit
// Blends an ARGB8888 source color over the stored pixel, packs the result
// into the configured channel layout and computes its framebuffer offset.
// ----------------------------------------------------------------------------
module alpha_blend_pixel_format_write_unit (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  abpfw_pkg::req_payload_type                 req_payload,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output abpfw_pkg::rsp_payload_type                 rsp_payload,
   input  logic                                       csr_we,
   input  logic [abpfw_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [abpfw_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);
   import abpfw_pkg::*;

   function automatic logic [7:0] unpack_channel(input logic [31:0] raw,
                                                 input logic [3:0]  size,
                                                 input logic [4:0]  pos);
      logic [31:0] shifted;
      logic [8:0]  field_mask;
      logic [8:0]  fill_mask;
      logic [7:0]  v;
      logic [7:0]  c;
      logic [3:0]  gap;
      shifted    = raw >> pos;
      field_mask = (9'd1 << size) - 9'd1;
      gap        = 4'd8 - size;
      fill_mask  = (9'd1 << gap) - 9'd1;
      v          = shifted[7:0] & field_mask[7:0];
      c          = v << gap;
      if (size == 4'd0) begin
         c = 8'd0;
      end else if (size >= 4'd4) begin
         c = c | (c >> size);
      end else if (v[0]) begin
         c = c | fill_mask[7:0];
      end
      return c;
   endfunction

   function automatic logic [31:0] pack_channel(input logic [7:0] c,
                                                input logic [3:0] size,
                                                input logic [4:0] pos);
      logic [31:0] field;
      logic [3:0]  gap;
      gap   = 4'd8 - size;
      field = {24'd0, c >> gap};
      if (size == 4'd0) begin
         return 32'd0;
      end
      return field << pos;
   endfunction

   function automatic logic [3:0] clamp_size(input logic [3:0] raw_size);
      return (raw_size > 4'd8) ? 4'd8 : raw_size;
   endfunction

   // Configuration registers.
   logic [15:0] channel_sizes_ff;
   logic [19:0] channel_positions_ff;
   logic [2:0]  bytes_per_pixel_ff;
   logic [15:0] line_pitch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_sizes_ff     <= 16'h8888;
         channel_positions_ff <= 20'hC4100;
         bytes_per_pixel_ff   <= 3'd4;
         line_pitch_ff        <= 16'd4096;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHANNEL_SIZES:     channel_sizes_ff     <= csr_wdata[15:0];
            CSR_CHANNEL_POSITIONS: channel_positions_ff <= csr_wdata[19:0];
            CSR_BYTES_PER_PIXEL:   bytes_per_pixel_ff   <= csr_wdata[2:0];
            CSR_LINE_PITCH:        line_pitch_ff        <= csr_wdata[15:0];
            default:               line_pitch_ff        <= line_pitch_ff;
         endcase
      end
   end

   logic [3:0]  size_b, size_g, size_r, size_a;
   logic [4:0]  pos_b, pos_g, pos_r, pos_a;
   logic [2:0]  bpp;
   logic [31:0] byte_mask;

   always_comb begin
      size_b = clamp_size(channel_sizes_ff[3:0]);
      size_g = clamp_size(channel_sizes_ff[7:4]);
      size_r = clamp_size(channel_sizes_ff[11:8]);
      size_a = clamp_size(channel_sizes_ff[15:12]);
      pos_b  = channel_positions_ff[4:0];
      pos_g  = channel_positions_ff[9:5];
      pos_r  = channel_positions_ff[14:10];
      pos_a  = channel_positions_ff[19:15];
      priority if (bytes_per_pixel_ff < 3'd2) begin
         bpp = 3'd2;
      end else if (bytes_per_pixel_ff > 3'd4) begin
         bpp = 3'd4;
      end else begin
         bpp = bytes_per_pixel_ff;
      end
      unique case (bpp)
         3'd2:    byte_mask = 32'h0000_ffff;
         3'd3:    byte_mask = 32'h00ff_ffff;
         default: byte_mask = 32'hffff_ffff;
      endcase
   end

   // Stage advance: a stage moves when the one after it is empty or moving.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_en, s2_en, s3_en;

   assign s3_en     = !s3_valid_ff || !rsp_stall;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Stage 1: unpack the stored pixel and form the offset partial products.
   logic [31:0] dst_masked;
   logic [23:0] s1_cur_in, s1_cur_ff;
   logic [31:0] s1_src_ff;
   logic [27:0] s1_y_prod_in, s1_y_prod_ff;
   logic [14:0] s1_x_prod_in, s1_x_prod_ff;

   always_comb begin
      dst_masked   = req_payload.dst_raw & byte_mask;
      s1_cur_in    = {unpack_channel(dst_masked, size_r, pos_r),
                      unpack_channel(dst_masked, size_g, pos_g),
                      unpack_channel(dst_masked, size_b, pos_b)};
      s1_y_prod_in = 28'(req_payload.y_pos) * 28'(line_pitch_ff);
      s1_x_prod_in = 15'(req_payload.x_pos) * 15'(bpp);
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_cur_ff    <= s1_cur_in;
         s1_src_ff    <= req_payload.src_pixel;
         s1_y_prod_ff <= s1_y_prod_in;
         s1_x_prod_ff <= s1_x_prod_in;
      end
   end

   // Stage 2: weighted blend per color channel and the offset sum.
   logic [7:0]  alpha;
   logic [8:0]  weight_src, weight_dst;
   logic [23:0] s2_pix_in, s2_pix_ff;
   logic [16:0] blend_sum [3];
   logic        s2_we_ff;
   logic [27:0] s2_offset_in, s2_offset_ff;

   always_comb begin
      alpha      = s1_src_ff[31:24];
      weight_src = {1'b0, alpha} + 9'd1;
      weight_dst = 9'd256 - {1'b0, alpha};
      for (int i = 0; i < 3; i++) begin
         blend_sum[i] = 17'(s1_src_ff[8*i +: 8]) * 17'(weight_src)
                      + 17'(s1_cur_ff[8*i +: 8]) * 17'(weight_dst);
         s2_pix_in[8*i +: 8] = (alpha == 8'hff) ? s1_src_ff[8*i +: 8]
                                                : blend_sum[i][15:8];
      end
      s2_offset_in = s1_y_prod_ff + 28'(s1_x_prod_ff);
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_pix_ff    <= s2_pix_in;
         s2_we_ff     <= (alpha != 8'd0);
         s2_offset_ff <= s2_offset_in;
      end
   end

   // Stage 3: pack into the stored layout; the alpha field is always opaque.
   logic [31:0]     packed_value;
   rsp_payload_type s3_payload_in, s3_payload_ff;

   always_comb begin
      packed_value = pack_channel(s2_pix_ff[7:0], size_b, pos_b)
                   | pack_channel(s2_pix_ff[15:8], size_g, pos_g)
                   | pack_channel(s2_pix_ff[23:16], size_r, pos_r)
                   | pack_channel(8'hff, size_a, pos_a);
      s3_payload_in.write_enable = s2_we_ff;
      s3_payload_in.byte_offset  = s2_offset_ff;
      s3_payload_in.pixel_value  = s2_we_ff ? (packed_value & byte_mask) : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_payload_ff <= s3_payload_in;
      end
   end

   assign rsp_valid   = s3_valid_ff;
   assign rsp_payload = s3_payload_ff;

endmodule

FILE: hdl/abpfw_checker.sv
// ----------------------------------------------------------------------------
// Alpha blend pixel format write checker
// Port-level checks on the unit's handshakes and response contents.
// ----------------------------------------------------------------------------
`include "alpha_blend_pixel_format_write_unit_defines.svh"

module abpfw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input abpfw_pkg::rsp_payload_type  rsp_payload
);
   import abpfw_pkg::*;

   // A stalled response transaction must hold.
   `ABPFW_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "response changed while stalled")

   // The unit only pushes back when its output is full and stalled.
   `ABPFW_ASSERT(a_req_stall_cause, req_stall |-> rsp_valid && rsp_stall, "request stalled without output back-pressure")

   // A skipped write carries a zero pixel.
   `ABPFW_ASSERT(a_skip_zero, rsp_valid && !rsp_payload.write_enable |-> rsp_payload.pixel_value == 32'd0, "nonzero pixel on a skipped write")

   // Reset empties the pipeline.
   `ABPFW_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "response valid right after reset")

endmodule

bind alpha_blend_pixel_format_write_unit abpfw_checker u_abpfw_checker (.*);
